>>> rtl/pfgs_pkg.sv
// Shared constants and helper functions for the potential-field goal steering block.
package pfgs_pkg;

    localparam int MAX_BEAMS = 1024;
    localparam int STEPS     = 20;

    localparam logic signed [33:0] PI_Q      = 34'sd3294199;
    localparam logic signed [33:0] HALF_PI_Q = 34'sd1647099;
    localparam logic signed [33:0] TWO_PI_Q  = 34'sd6588397;
    localparam logic [19:0]        GAIN_K    = 20'd636751;

    localparam logic signed [39:0] S40_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] S40_MIN = 40'sh80_0000_0000;

    localparam logic [47:0] LIN_DEN  = 48'd25600;
    localparam logic [47:0] LIN_HALF = 48'd12800;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ANGLE_START  = 3'd0;
    localparam logic [2:0] REG_ANGLE_STEP   = 3'd1;
    localparam logic [2:0] REG_FRONT_FIRST  = 3'd2;
    localparam logic [2:0] REG_FRONT_LAST   = 3'd3;
    localparam logic [2:0] REG_INFLUENCE    = 3'd4;
    localparam logic [2:0] REG_ARRIVAL      = 3'd5;
    localparam logic [2:0] REG_MIN_RANGE    = 3'd6;

    typedef logic signed [39:0] t_s40;

    function automatic logic [19:0] arc_tab(input logic [4:0] i);
        logic [19:0] v;
        case (i)
            5'd0:  v = 20'd823550;
            5'd1:  v = 20'd486170;
            5'd2:  v = 20'd256879;
            5'd3:  v = 20'd130396;
            5'd4:  v = 20'd65451;
            5'd5:  v = 20'd32757;
            5'd6:  v = 20'd16383;
            5'd7:  v = 20'd8192;
            5'd8:  v = 20'd4096;
            5'd9:  v = 20'd2048;
            5'd10: v = 20'd1024;
            5'd11: v = 20'd512;
            5'd12: v = 20'd256;
            5'd13: v = 20'd128;
            5'd14: v = 20'd64;
            5'd15: v = 20'd32;
            5'd16: v = 20'd16;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    function automatic t_s40 sat40(input logic signed [49:0] v);
        t_s40 r;
        if (v > 50'(S40_MAX)) begin
            r = S40_MAX;
        end else if (v < 50'(S40_MIN)) begin
            r = S40_MIN;
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/potential_field_goal_steering.sv
// Top level of the potential-field goal steering block.
//
// Input channel (i_valid/o_ready) carries either a laser beam sample (i_func=0)
// or a control tick (i_func=1). A beam produces no result; it only updates the
// repulsion sums, and a beam with i_last_beam set closes the scan. A control
// tick produces exactly one transfer on the output channel (o_valid/i_ready).
// One item is worked on at a time; o_ready is high only between items.
// An ignored beam skips the arithmetic. A counted beam runs angle reduction,
// 20 CORDIC rotation steps and two restoring divisions. A control tick runs
// 20 CORDIC vectoring steps and one division; a zero offset goal skips the
// vectoring, and a goal within arrival range skips both.
// The result sits in an output register, so a stalled receiver only holds the
// block when the next control tick is ready to deliver its own result.
// Synchronous active-low reset clears the sums, the stored repulsion and the
// output valid flag, and loads the default configuration.
module potential_field_goal_steering (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [9:0]         i_beam_index,
    input  logic [15:0]        i_range_mm,
    input  logic               i_range_invalid,
    input  logic               i_last_beam,
    input  logic signed [19:0] i_goal_x_mm,
    input  logic signed [19:0] i_goal_y_mm,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [10:0] o_angular_mrad_s,
    output logic [9:0]         o_linear_mm_s,
    output logic               o_goal_reached
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_AMUL = 5'd1;
    localparam logic [4:0] S_AWRAP = 5'd2;
    localparam logic [4:0] S_RED  = 5'd3;
    localparam logic [4:0] S_FOLD = 5'd4;
    localparam logic [4:0] S_ROT  = 5'd5;
    localparam logic [4:0] S_DMUL = 5'd6;
    localparam logic [4:0] S_NMUL = 5'd7;
    localparam logic [4:0] S_DIV  = 5'd8;
    localparam logic [4:0] S_ACC  = 5'd9;
    localparam logic [4:0] S_FIN  = 5'd10;
    localparam logic [4:0] S_SQX  = 5'd11;
    localparam logic [4:0] S_SQY  = 5'd12;
    localparam logic [4:0] S_SQA  = 5'd13;
    localparam logic [4:0] S_CMP  = 5'd14;
    localparam logic [4:0] S_VEC0 = 5'd15;
    localparam logic [4:0] S_MH   = 5'd16;
    localparam logic [4:0] S_ML   = 5'd17;
    localparam logic [4:0] S_LMUL = 5'd18;
    localparam logic [4:0] S_OUT  = 5'd19;

    // Configuration registers.
    logic signed [22:0] r_astart;
    logic [20:0]        r_astep;
    logic [9:0]         r_ffirst;
    logic [9:0]         r_flast;
    logic [15:0]        r_infl;
    logic [15:0]        r_arr;
    logic [15:0]        r_minr;

    // Scan and repulsion state.
    pfgs_pkg::t_s40     r_sum_x;
    pfgs_pkg::t_s40     r_sum_y;
    pfgs_pkg::t_s40     r_rep_x;
    pfgs_pkg::t_s40     r_rep_y;
    logic               r_front;

    // Sequencer and working registers.
    logic [4:0]         r_state;
    logic [5:0]         r_cnt;
    logic [9:0]         r_idx;
    logic [15:0]        r_d;
    logic               r_last;
    logic [25:0]        r_r1k;
    logic signed [19:0] r_gx;
    logic signed [19:0] r_gy;
    logic signed [33:0] r_a;
    logic signed [41:0] r_x;
    logic signed [41:0] r_y;
    logic signed [24:0] r_z;
    logic               r_rot;
    logic               r_neg;
    logic               r_sel;
    logic               r_dsel;
    logic [47:0]        r_num;
    logic               r_nsgn;
    logic [35:0]        r_den;
    logic [35:0]        r_rem;
    logic [40:0]        r_sq;
    logic [31:0]        r_arsq;
    logic [42:0]        r_m;
    logic               r_reach;
    logic               r_ovalid;
    logic signed [10:0] r_oang;
    logic [9:0]         r_olin;
    logic               r_oreach;

    logic               w_wr;
    logic               w_acc;
    logic               w_obs;
    logic               w_idx_ok;
    logic               w_bvalid;
    logic               w_bfront;
    logic [15:0]        w_dfl;
    logic [15:0]        w_d;
    logic [30:0]        w_aprod;
    logic [33:0]        w_redk;
    logic signed [33:0] w_fa;
    logic signed [41:0] w_xs;
    logic signed [41:0] w_ys;
    logic signed [24:0] w_arc;
    logic               w_up;
    logic signed [23:0] w_cs;
    logic signed [23:0] w_csn;
    logic signed [50:0] w_np;
    logic [50:0]        w_pabs;
    logic [36:0]        w_trial;
    logic               w_ge;
    logic signed [49:0] w_q;
    logic signed [49:0] w_sacc;
    logic signed [44:0] w_rx10;
    logic signed [44:0] w_ry10;
    logic signed [44:0] w_rxr;
    logic signed [44:0] w_ryr;
    logic signed [41:0] w_tx;
    logic signed [41:0] w_ty;
    logic [39:0]        w_lo;
    logic signed [33:0] w_angp;
    logic signed [33:0] w_angr;
    logic signed [10:0] w_ang;
    logic [9:0]         w_lin;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite;
    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign w_obs   = (r_rep_x != '0) && (r_rep_y != '0);

    assign o_valid          = r_ovalid;
    assign o_angular_mrad_s = r_oang;
    assign o_linear_mm_s    = r_olin;
    assign o_goal_reached   = r_oreach;

    always_comb begin
        case (paddr[4:2])
            pfgs_pkg::REG_ANGLE_START: prdata = 32'(r_astart);
            pfgs_pkg::REG_ANGLE_STEP:  prdata = 32'(r_astep);
            pfgs_pkg::REG_FRONT_FIRST: prdata = 32'(r_ffirst);
            pfgs_pkg::REG_FRONT_LAST:  prdata = 32'(r_flast);
            pfgs_pkg::REG_INFLUENCE:   prdata = 32'(r_infl);
            pfgs_pkg::REG_ARRIVAL:     prdata = 32'(r_arr);
            pfgs_pkg::REG_MIN_RANGE:   prdata = 32'(r_minr);
            default:                   prdata = 32'd0;
        endcase
    end

    // Beam qualification at the input.
    always_comb begin
        w_idx_ok = {3'd0, i_beam_index} < 13'(pfgs_pkg::MAX_BEAMS);
        w_bvalid = !i_range_invalid && w_idx_ok;
        w_bfront = (i_beam_index >= r_ffirst) && (i_beam_index <= r_flast);
        w_dfl    = (i_range_mm > r_minr) ? i_range_mm : r_minr;
        w_d      = (w_dfl == 16'd0) ? 16'd1 : w_dfl;
    end

    // Angle arithmetic and one shared CORDIC step.
    always_comb begin
        w_aprod = 31'(r_idx) * 31'(r_astep);
        w_redk  = 34'(pfgs_pkg::TWO_PI_Q) << r_cnt[3:0];
        w_fa    = (r_a > pfgs_pkg::PI_Q) ? (r_a - pfgs_pkg::TWO_PI_Q) : r_a;
        w_xs    = r_x >>> r_cnt[4:0];
        w_ys    = r_y >>> r_cnt[4:0];
        w_arc   = $signed({5'd0, pfgs_pkg::arc_tab(r_cnt[4:0])});
        w_up    = r_rot ? (r_z >= 0) : (r_y < 0);
    end

    // Numerator of a repulsion term, the restoring division step and the sum update.
    always_comb begin
        w_cs    = r_sel ? r_y[23:0] : r_x[23:0];
        w_csn   = r_neg ? -w_cs : w_cs;
        w_np    = 51'($signed({1'b0, r_r1k})) * 51'(w_csn);
        w_pabs  = (w_np < 0) ? 51'(-w_np) : 51'(w_np);
        w_trial = {r_rem, r_num[47]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_q     = r_nsgn ? -$signed({2'b00, r_num}) : $signed({2'b00, r_num});
        w_sacc  = 50'(r_sel ? r_sum_y : r_sum_x) + w_q;
    end

    // Goal offset by the repulsion, rounded from Q16 times ten down to Q8, and the low half of the magnitude scaling.
    always_comb begin
        w_rx10 = (45'(r_rep_x) <<< 3) + (45'(r_rep_x) <<< 1);
        w_ry10 = (45'(r_rep_y) <<< 3) + (45'(r_rep_y) <<< 1);
        w_rxr  = (w_rx10 < 0) ? -((-w_rx10 + 45'sd128) >>> 8) : ((w_rx10 + 45'sd128) >>> 8);
        w_ryr  = (w_ry10 < 0) ? -((-w_ry10 + 45'sd128) >>> 8) : ((w_ry10 + 45'sd128) >>> 8);
        w_tx   = (42'(r_gx) <<< 8) + 42'(w_rxr);
        w_ty   = (42'(r_gy) <<< 8) + 42'(w_ryr);
        w_lo   = (40'(r_x[19:0]) * 40'(pfgs_pkg::GAIN_K) + 40'd524288) >> 20;
    end

    // Speed commands from the heading angle and the divided magnitude.
    always_comb begin
        w_angp = 34'(r_z) * (w_obs ? 34'sd120 : 34'sd200);
        w_angr = (w_angp < 0) ? -((-w_angp + 34'sd524288) >>> 20)
                              : ((w_angp + 34'sd524288) >>> 20);
        w_ang  = (w_angr > 34'sd800) ? 11'sd800 : w_angr[10:0];
        w_lin  = (r_num > 48'd1000) ? 10'd1000 : r_num[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_astart <= -23'sd524288;
            r_astep  <= 21'd1716;
            r_ffirst <= 10'd161;
            r_flast  <= 10'd448;
            r_infl   <= 16'd3000;
            r_arr    <= 16'd500;
            r_minr   <= 16'd100;
        end else if (w_wr) begin
            case (paddr[4:2])
                pfgs_pkg::REG_ANGLE_START: r_astart <= pwdata[22:0];
                pfgs_pkg::REG_ANGLE_STEP:  r_astep  <= pwdata[20:0];
                pfgs_pkg::REG_FRONT_FIRST: r_ffirst <= pwdata[9:0];
                pfgs_pkg::REG_FRONT_LAST:  r_flast  <= pwdata[9:0];
                pfgs_pkg::REG_INFLUENCE:   r_infl   <= pwdata[15:0];
                pfgs_pkg::REG_ARRIVAL:     r_arr    <= pwdata[15:0];
                pfgs_pkg::REG_MIN_RANGE:   r_minr   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_rep_x  <= '0;
            r_rep_y  <= '0;
            r_front  <= 1'b0;
        end else begin
            // In the delivery state the output register is handled below.
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_idx  <= i_beam_index;
                        r_d    <= w_d;
                        r_last <= i_last_beam;
                        r_r1k  <= 26'(i_range_mm) * 26'd1000;
                        r_gx   <= i_goal_x_mm;
                        r_gy   <= i_goal_y_mm;
                        if (i_func) begin
                            r_state <= S_SQX;
                        end else begin
                            if (w_bvalid && w_bfront) begin
                                r_front <= 1'b1;
                            end
                            r_state <= (w_bvalid && (w_d < r_infl)) ? S_AMUL : S_FIN;
                        end
                    end
                end
                S_AMUL: begin
                    r_a     <= 34'(r_astart) + $signed({3'd0, w_aprod});
                    r_state <= S_AWRAP;
                end
                S_AWRAP: begin
                    if (r_a < 0) begin
                        r_a <= r_a + pfgs_pkg::TWO_PI_Q;
                    end
                    r_cnt   <= 6'd8;
                    r_state <= S_RED;
                end
                S_RED: begin
                    // Reduce modulo two pi, one binary multiple of it a cycle.
                    if ($unsigned(r_a) >= w_redk) begin
                        r_a <= r_a - $signed(w_redk);
                    end
                    if (r_cnt == 6'd0) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_FOLD: begin
                    if (w_fa > pfgs_pkg::HALF_PI_Q) begin
                        r_z   <= 25'(w_fa - pfgs_pkg::PI_Q);
                        r_neg <= 1'b1;
                    end else if (w_fa < -pfgs_pkg::HALF_PI_Q) begin
                        r_z   <= 25'(w_fa + pfgs_pkg::PI_Q);
                        r_neg <= 1'b1;
                    end else begin
                        r_z   <= 25'(w_fa);
                        r_neg <= 1'b0;
                    end
                    r_x     <= 42'(pfgs_pkg::GAIN_K);
                    r_y     <= '0;
                    r_rot   <= 1'b1;
                    r_cnt   <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (w_up) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_arc;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_arc;
                    end
                    if (r_cnt == 6'(pfgs_pkg::STEPS - 1)) begin
                        r_state <= r_rot ? S_DMUL : S_MH;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DMUL: begin
                    r_den   <= {36'(r_d) * 36'(r_d)} << 4;
                    r_sel   <= 1'b0;
                    r_state <= S_NMUL;
                end
                S_NMUL: begin
                    r_num   <= 48'(w_pabs) + 48'(r_den >> 1);
                    r_nsgn  <= w_np < 0;
                    r_rem   <= '0;
                    r_dsel  <= 1'b0;
                    r_cnt   <= 6'd47;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? 36'(w_trial - {1'b0, r_den}) : 36'(w_trial);
                    r_num <= {r_num[46:0], w_ge};
                    if (r_cnt == 6'd0) begin
                        r_state <= r_dsel ? S_OUT : S_ACC;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_ACC: begin
                    if (r_sel) begin
                        r_sum_y <= pfgs_pkg::sat40(w_sacc);
                        r_state <= S_FIN;
                    end else begin
                        r_sum_x <= pfgs_pkg::sat40(w_sacc);
                        r_sel   <= 1'b1;
                        r_state <= S_NMUL;
                    end
                end
                S_FIN: begin
                    if (r_last) begin
                        r_rep_x <= r_front ? pfgs_pkg::sat40(-50'(r_sum_x)) : '0;
                        r_rep_y <= r_front ? pfgs_pkg::sat40(-50'(r_sum_y)) : '0;
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                        r_front <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                S_SQX: begin
                    r_sq    <= 41'(40'(r_gx) * 40'(r_gx));
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sq    <= r_sq + 41'(40'(r_gy) * 40'(r_gy));
                    r_state <= S_SQA;
                end
                S_SQA: begin
                    r_arsq  <= 32'(r_arr) * 32'(r_arr);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_reach <= r_sq < 41'(r_arsq);
                    r_x     <= w_tx;
                    r_y     <= w_ty;
                    r_state <= (r_sq < 41'(r_arsq)) ? S_OUT : S_VEC0;
                end
                S_VEC0: begin
                    r_rot <= 1'b0;
                    r_cnt <= '0;
                    if (r_x == '0 && r_y == '0) begin
                        r_z     <= '0;
                        r_state <= S_MH;
                    end else if (r_x < 0) begin
                        r_z     <= (r_y >= 0) ? 25'(pfgs_pkg::PI_Q) : 25'(-pfgs_pkg::PI_Q);
                        r_x     <= -r_x;
                        r_y     <= -r_y;
                        r_state <= S_ROT;
                    end else begin
                        r_z     <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_MH: begin
                    r_m <= 43'(r_x[41:20]) * 43'(pfgs_pkg::GAIN_K);
                    if (r_z > 25'(pfgs_pkg::PI_Q)) begin
                        r_z <= 25'(pfgs_pkg::PI_Q);
                    end else if (r_z < 25'(-pfgs_pkg::PI_Q)) begin
                        r_z <= 25'(-pfgs_pkg::PI_Q);
                    end
                    r_state <= S_ML;
                end
                S_ML: begin
                    r_m     <= r_m + 43'(w_lo);
                    r_state <= S_LMUL;
                end
                S_LMUL: begin
                    r_num   <= 48'(r_m) * (w_obs ? 48'd9 : 48'd30) + pfgs_pkg::LIN_HALF;
                    r_den   <= 36'(pfgs_pkg::LIN_DEN);
                    r_nsgn  <= 1'b0;
                    r_rem   <= '0;
                    r_dsel  <= 1'b1;
                    r_cnt   <= 6'd47;
                    r_state <= S_DIV;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_oang   <= r_reach ? 11'sd0 : w_ang;
                        r_olin   <= r_reach ? 10'd0 : w_lin;
                        r_oreach <= r_reach;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_beam_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_func && !r_ovalid) |=> !r_ovalid)
        else $error("beam sample produced a result");

    a_rise_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT)
        else $error("result appeared outside the delivery state");

    a_rot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> r_cnt < 6'(pfgs_pkg::STEPS))
        else $error("CORDIC step count out of range");

    a_reached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oreach) |-> (r_oang == 11'sd0 && r_olin == 10'd0))
        else $error("speeds not zero with goal reached");

    a_lin_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_olin <= 10'd1000)
        else $error("linear speed above its limit");

endmodule
